### rtl/core/text_stream_cat_filter_macros.svh
// ----------------------------------------------------------------------------
// Text stream cat filter assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef TEXT_STREAM_CAT_FILTER_MACROS_SVH
`define TEXT_STREAM_CAT_FILTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSCF_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSCF_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/tscf_pkg.sv
// ----------------------------------------------------------------------------
// Text stream cat filter package
// Payload types, register indexes and character codes shared by the block.
// ----------------------------------------------------------------------------
package tscf_pkg;

	localparam int NUMBER_DIGITS_DEF = 6;

	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 1;

	localparam logic [CFG_INDEX_W-1:0] REG_SQUEEZE_BLANK    = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_ALL       = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_NUMBER_NONBLANK  = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SHOW_ENDS        = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_SHOW_TABS        = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SHOW_NONPRINTING = 3'd5;

	localparam logic [7:0] ASCII_TAB    = 8'd9;
	localparam logic [7:0] ASCII_NL     = 8'd10;
	localparam logic [7:0] ASCII_SPACE  = 8'd32;
	localparam logic [7:0] ASCII_DOLLAR = 8'd36;
	localparam logic [7:0] ASCII_ZERO   = 8'd48;
	localparam logic [7:0] ASCII_QUERY  = 8'd63;
	localparam logic [7:0] ASCII_I      = 8'd73;
	localparam logic [7:0] ASCII_CARET  = 8'd94;
	localparam logic [7:0] ASCII_DEL    = 8'd127;
	localparam logic [7:0] CTRL_LIMIT   = 8'd32;
	localparam logic [7:0] CARET_OFFSET = 8'd64;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       first_of_file;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
	} out_item_t;

	typedef struct packed {
		logic squeeze_blank;
		logic number_all;
		logic number_nonblank;
		logic show_ends;
		logic show_tabs;
		logic show_nonprinting;
	} cfg_t;

endpackage

### rtl/core/tscf_stream_if.sv
// ----------------------------------------------------------------------------
// Text stream cat filter stream interface
// Valid/ready channel carrying one payload item per transaction.
// ----------------------------------------------------------------------------
interface tscf_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

### rtl/core/text_stream_cat_filter.sv
// ----------------------------------------------------------------------------
// Text stream cat filter
// Line numbering, blank squeezing and visible control bytes on a byte stream.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload                      Handshake
//  in_ch     sink       in_byte, first_of_file       valid / ready
//  out_ch    source     out_byte, last_of_run        valid / ready
//  cfg       write      cfg_index, cfg_data          cfg_we, no wait
//
// An input transaction is worked out in the cycle it is accepted and its run
// of output bytes is loaded into the result register, one byte leaving per
// cycle while out_ch is ready: a plain byte is a run of 1 byte, a caret pair 2,
// a numbered line start NUMBER_DIGITS + 2 or + 3. The run length sets the rate.
// A new input is taken in the cycle the last byte of the current run leaves.
// arst_n clears configuration, line state and the output run.
// ----------------------------------------------------------------------------
module text_stream_cat_filter #(
	parameter int NUMBER_DIGITS = tscf_pkg::NUMBER_DIGITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_we,
	input  logic [tscf_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [tscf_pkg::CFG_DATA_W-1:0]  cfg_data,
	tscf_stream_if.sink                      in_ch,
	tscf_stream_if.source                    out_ch
);

	localparam int CNT_W   = 4 * NUMBER_DIGITS;
	localparam int PRE_N   = NUMBER_DIGITS + 1;
	localparam int PRE_IW  = $clog2(PRE_N);
	localparam int RUN_MAX = PRE_N + 2;
	localparam int POS_W   = $clog2(RUN_MAX + 1);
	localparam logic [POS_W-1:0] PRE_LEN = POS_W'(PRE_N);

	tscf_pkg::cfg_t      cfg_q;
	tscf_pkg::in_item_t  in_item;
	tscf_pkg::out_item_t out_item;

	logic [7:0]       prev_byte_q;
	logic             blank_held_q;
	logic [CNT_W-1:0] line_num_q;

	// Output run: optional number prefix followed by one or two body bytes.
	logic             run_valid_q;
	logic [POS_W-1:0] pos_q;
	logic [POS_W-1:0] len_q;
	logic             num_q;
	logic [7:0]       pre_q [PRE_N];
	logic [7:0]       body_q [2];

	logic             in_acc;
	logic             out_fire;
	logic             run_last;
	logic             first;
	logic [7:0]       c;
	logic [7:0]       prev_eff;
	logic             held_eff;
	logic [CNT_W-1:0] num_eff;
	logic             line_start;
	logic             is_nl;
	logic             blank_line;
	logic             drop;
	logic             blank_held_d;
	logic             want_num;
	logic             all_nines;
	logic [CNT_W-1:0] num_inc;
	logic [CNT_W-1:0] line_num_d;
	logic [7:0]       pre_d [PRE_N];
	logic [7:0]       body_d [2];
	logic [1:0]       body_len_d;
	logic [POS_W-1:0] run_len_d;
	logic [POS_W-1:0] body_off;
	logic [7:0]       out_byte;

	assign in_item  = in_ch.payload;
	assign c        = in_item.in_byte;
	assign first    = in_item.first_of_file;
	assign in_acc   = in_ch.valid && in_ch.ready;
	assign out_fire = run_valid_q && out_ch.ready;
	assign run_last = (pos_q == len_q - POS_W'(1));

	assign in_ch.ready = !run_valid_q || (out_ch.ready && run_last);

	// A new file starts from the reset line state.
	assign prev_eff   = first ? tscf_pkg::ASCII_NL : prev_byte_q;
	assign held_eff   = first ? 1'b0 : blank_held_q;
	assign num_eff    = first ? CNT_W'(1) : line_num_q;
	assign line_start = (prev_eff == tscf_pkg::ASCII_NL);
	assign is_nl      = (c == tscf_pkg::ASCII_NL);
	assign blank_line = line_start && is_nl;
	assign drop       = blank_line && cfg_q.squeeze_blank && held_eff;

	assign blank_held_d = blank_line ? 1'b1 : (is_nl ? held_eff : 1'b0);
	assign want_num     = !drop && line_start &&
		(cfg_q.number_nonblank ? !is_nl : cfg_q.number_all);

	// Saturating BCD increment of the line counter.
	always_comb begin
		logic       carry;
		logic [3:0] d;
		carry     = 1'b1;
		all_nines = 1'b1;
		num_inc   = num_eff;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			d = num_eff[4*i +: 4];
			if (d != 4'd9) begin
				all_nines = 1'b0;
			end
			if (carry) begin
				if (d < 4'd9) begin
					num_inc[4*i +: 4] = d + 4'd1;
					carry = 1'b0;
				end else begin
					num_inc[4*i +: 4] = 4'd0;
				end
			end
		end
	end

	assign line_num_d = (want_num && !all_nines) ? num_inc : num_eff;

	// Number prefix, most significant digit first, leading zeros as spaces.
	always_comb begin
		logic       started;
		logic [3:0] d;
		started = 1'b0;
		for (int k = 0; k < NUMBER_DIGITS; k++) begin
			d = num_eff[4*(NUMBER_DIGITS-1-k) +: 4];
			if (d > 4'd9) begin
				d = 4'd9;
			end
			if (d != 4'd0 || k == NUMBER_DIGITS - 1) begin
				started = 1'b1;
			end
			pre_d[k] = started ? (tscf_pkg::ASCII_ZERO + {4'd0, d}) : tscf_pkg::ASCII_SPACE;
		end
		pre_d[NUMBER_DIGITS] = tscf_pkg::ASCII_TAB;
	end

	// Body bytes; newline and tab are checked before the caret forms.
	always_comb begin
		body_d[0]  = c;
		body_d[1]  = c;
		body_len_d = 2'd1;
		if (is_nl) begin
			if (cfg_q.show_ends) begin
				body_d[0]  = tscf_pkg::ASCII_DOLLAR;
				body_len_d = 2'd2;
			end
		end else if (c == tscf_pkg::ASCII_TAB) begin
			if (cfg_q.show_tabs) begin
				body_d[0]  = tscf_pkg::ASCII_CARET;
				body_d[1]  = tscf_pkg::ASCII_I;
				body_len_d = 2'd2;
			end
		end else if (cfg_q.show_nonprinting && c < tscf_pkg::CTRL_LIMIT) begin
			body_d[0]  = tscf_pkg::ASCII_CARET;
			body_d[1]  = c + tscf_pkg::CARET_OFFSET;
			body_len_d = 2'd2;
		end else if (cfg_q.show_nonprinting && c == tscf_pkg::ASCII_DEL) begin
			body_d[0]  = tscf_pkg::ASCII_CARET;
			body_d[1]  = tscf_pkg::ASCII_QUERY;
			body_len_d = 2'd2;
		end
	end

	assign run_len_d = (want_num ? PRE_LEN : '0) + POS_W'(body_len_d);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				tscf_pkg::REG_SQUEEZE_BLANK:    cfg_q.squeeze_blank    <= cfg_data[0];
				tscf_pkg::REG_NUMBER_ALL:       cfg_q.number_all       <= cfg_data[0];
				tscf_pkg::REG_NUMBER_NONBLANK:  cfg_q.number_nonblank  <= cfg_data[0];
				tscf_pkg::REG_SHOW_ENDS:        cfg_q.show_ends        <= cfg_data[0];
				tscf_pkg::REG_SHOW_TABS:        cfg_q.show_tabs        <= cfg_data[0];
				tscf_pkg::REG_SHOW_NONPRINTING: cfg_q.show_nonprinting <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_byte_q  <= tscf_pkg::ASCII_NL;
			blank_held_q <= 1'b0;
			line_num_q   <= CNT_W'(1);
		end else if (in_acc) begin
			prev_byte_q  <= c;
			blank_held_q <= blank_held_d;
			line_num_q   <= line_num_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_valid_q <= 1'b0;
			pos_q       <= '0;
		end else if (in_acc) begin
			run_valid_q <= !drop;
			pos_q       <= '0;
		end else if (out_fire) begin
			if (run_last) begin
				run_valid_q <= 1'b0;
			end else begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			len_q  <= run_len_d;
			num_q  <= want_num;
			pre_q  <= pre_d;
			body_q <= body_d;
		end
	end

	assign body_off = pos_q - (num_q ? PRE_LEN : '0);
	assign out_byte = (num_q && pos_q < PRE_LEN) ? pre_q[pos_q[PRE_IW-1:0]] :
		body_q[body_off[0]];

	assign out_item.out_byte    = out_byte;
	assign out_item.last_of_run = run_last;
	assign out_ch.payload       = out_item;
	assign out_ch.valid         = run_valid_q;

endmodule

### rtl/core/tscf_checker.sv
// ----------------------------------------------------------------------------
// Text stream cat filter checker
// Port-level assertions on the stream channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "text_stream_cat_filter_macros.svh"

module tscf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic [7:0] in_byte,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_byte,
	input logic       out_last
);

	`TSCF_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last), "stalled output transaction changed")

	// A run leaves without gaps until its last byte.
	`TSCF_ASSERT_NEXT(a_run_unbroken, out_valid && out_ready && !out_last, out_valid, "output run broke off before its last byte")

	`TSCF_ASSERT_NOW(a_ready_at_run_end, in_ready, !out_valid || (out_ready && out_last), "input taken while an output run was still pending")

	// Only a squeezed blank line may vanish, and that is always a newline.
	`TSCF_ASSERT_NEXT(a_byte_emits, in_valid && in_ready && in_byte != tscf_pkg::ASCII_NL, out_valid, "non-newline input produced no output")

endmodule

bind text_stream_cat_filter tscf_checker u_tscf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_byte   (in_ch.payload.in_byte),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_byte  (out_ch.payload.out_byte),
	.out_last  (out_ch.payload.last_of_run)
);

### dv/text_stream_cat_filter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text stream cat filter testbench
// Sends text bytes through the filter under a series of register settings
// and compares every output byte against a cycle-free model of the filter,
// with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module text_stream_cat_filter_test;
	import tscf_pkg::*;

	localparam int DIGITS      = NUMBER_DIGITS_DEF;
	localparam int SETTLE      = DIGITS + 10;
	localparam int DRAIN_LIMIT = 50000;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	tscf_stream_if #(.payload_t(in_item_t))  in_ch ();
	tscf_stream_if #(.payload_t(out_item_t)) out_ch ();

	text_stream_cat_filter dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_ch     (in_ch),
		.out_ch    (out_ch)
	);

	// Model state and settings.
	cfg_t                cfg_now;
	logic [7:0]          prev_byte;
	logic                blank_held;
	logic [4*DIGITS-1:0] line_bcd;

	in_item_t  raw_bytes_q[$];
	out_item_t bytes_due[$];

	bit next_first;
	bit in_flight;
	bit idle_on;
	int in_gap;
	int out_stall;
	int fail_count;
	int bytes_sent;
	int bytes_checked;
	int lines_numbered;
	int blanks_squeezed;
	int settings_used;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5ms;
		$display("== FAIL ==");
		$finish;
	end

	function automatic void add_due(logic [7:0] b);
		out_item_t o;
		o.out_byte    = b;
		o.last_of_run = 1'b0;
		bytes_due.push_back(o);
	endfunction

	// Works out the output run of one accepted byte and appends it to bytes_due.
	function automatic void cat_predict(in_item_t it);
		logic [7:0]          c;
		logic                line_start;
		logic                blank_line;
		logic                all_nines;
		logic                started;
		logic [3:0]          d;
		logic [4*DIGITS-1:0] nxt;
		c = it.in_byte;
		if (it.first_of_file) begin
			prev_byte  = ASCII_NL;
			blank_held = 1'b0;
			line_bcd   = (4*DIGITS)'(1);
		end
		line_start = (prev_byte == ASCII_NL);
		blank_line = line_start && (c == ASCII_NL);
		prev_byte  = c;
		if (blank_line) begin
			if (cfg_now.squeeze_blank && blank_held) begin
				blanks_squeezed++;
				return;
			end
			blank_held = 1'b1;
		end else if (c != ASCII_NL) begin
			blank_held = 1'b0;
		end
		if (line_start && (cfg_now.number_nonblank ? (c != ASCII_NL) : cfg_now.number_all)) begin
			started = 1'b0;
			for (int i = DIGITS - 1; i >= 0; i--) begin
				d = line_bcd[4*i +: 4];
				if (d > 4'd9)
					d = 4'd9;
				if (d != 4'd0 || i == 0)
					started = 1'b1;
				add_due(started ? ASCII_ZERO + 8'(d) : ASCII_SPACE);
			end
			add_due(ASCII_TAB);
			lines_numbered++;
			// The counter sticks once every digit is a nine.
			all_nines = 1'b1;
			for (int i = 0; i < DIGITS; i++)
				if (line_bcd[4*i +: 4] != 4'd9)
					all_nines = 1'b0;
			if (!all_nines) begin
				nxt = line_bcd;
				for (int i = 0; i < DIGITS; i++) begin
					if (nxt[4*i +: 4] < 4'd9) begin
						nxt[4*i +: 4] = nxt[4*i +: 4] + 4'd1;
						break;
					end
					nxt[4*i +: 4] = 4'd0;
				end
				line_bcd = nxt;
			end
		end
		if (c == ASCII_NL) begin
			if (cfg_now.show_ends)
				add_due(ASCII_DOLLAR);
			add_due(ASCII_NL);
		end else if (c == ASCII_TAB) begin
			if (cfg_now.show_tabs) begin
				add_due(ASCII_CARET);
				add_due(ASCII_I);
			end else begin
				add_due(ASCII_TAB);
			end
		end else if (cfg_now.show_nonprinting && c < CTRL_LIMIT) begin
			add_due(ASCII_CARET);
			add_due(c + CARET_OFFSET);
		end else if (cfg_now.show_nonprinting && c == ASCII_DEL) begin
			add_due(ASCII_CARET);
			add_due(ASCII_QUERY);
		end else begin
			add_due(c);
		end
		bytes_due[bytes_due.size() - 1].last_of_run = 1'b1;
	endfunction

	// Input driver: valid is held until the transaction completes.
	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid   <= 1'b0;
			in_ch.payload <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				cat_predict(in_ch.payload);
				in_flight = 1'b0;
				bytes_sent++;
			end
			if (!(in_ch.valid && !in_ch.ready)) begin
				if (in_gap > 0) begin
					in_gap--;
					in_ch.valid <= 1'b0;
				end else if (raw_bytes_q.size() > 0) begin
					in_ch.valid   <= 1'b1;
					in_ch.payload <= raw_bytes_q.pop_front();
					in_flight = 1'b1;
					if (idle_on && $urandom_range(0, 7) == 0)
						in_gap = $urandom_range(1, 12);
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Output monitor and ready generator.
	always @(posedge clk) begin
		out_item_t got;
		out_item_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				got = out_ch.payload;
				bytes_checked++;
				if (bytes_due.size() == 0) begin
					$error("unexpected output byte %02h (last_of_run %0b)", got.out_byte,
						got.last_of_run);
					fail_count++;
				end else begin
					want = bytes_due.pop_front();
					if (got.out_byte !== want.out_byte) begin
						$error("out_byte: expected %02h, actual %02h", want.out_byte, got.out_byte);
						fail_count++;
					end
					if (got.last_of_run !== want.last_of_run) begin
						$error("last_of_run: expected %0b, actual %0b", want.last_of_run,
							got.last_of_run);
						fail_count++;
					end
				end
			end
			if (out_stall > 0) begin
				out_stall--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				if (idle_on && $urandom_range(0, 7) == 0)
					out_stall = $urandom_range(1, 12);
			end
		end
	end

	function automatic void queue_raw(logic [7:0] b, logic first);
		in_item_t it;
		it.in_byte       = b;
		it.first_of_file = first | next_first;
		next_first = 1'b0;
		raw_bytes_q.push_back(it);
	endfunction

	function automatic logic [7:0] text_char();
		int r;
		r = $urandom_range(0, 19);
		if (r <= 11)
			return 8'($urandom_range(32, 126));
		else if (r == 12)
			return ASCII_TAB;
		else if (r == 13)
			return 8'($urandom_range(0, 31));
		else if (r == 14)
			return ASCII_DEL;
		else if (r <= 16)
			return 8'($urandom_range(128, 255));
		else if (r == 17)
			return 8'hFF;
		else
			return ASCII_SPACE;
	endfunction

	// Mostly well-formed lines and blank runs, with some raw noise and file breaks.
	task automatic queue_text(int target);
		int n;
		int k;
		int r;
		n = 0;
		while (n < target) begin
			r = $urandom_range(0, 9);
			if (r <= 5) begin
				k = $urandom_range(0, 8);
				repeat (k) queue_raw(text_char(), 1'b0);
				queue_raw(ASCII_NL, 1'b0);
				n += k + 1;
			end else if (r <= 7) begin
				k = $urandom_range(1, 4);
				repeat (k) queue_raw(ASCII_NL, 1'b0);
				n += k;
			end else if (r == 8) begin
				k = $urandom_range(1, 3);
				repeat (k) queue_raw(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				n += k;
			end else begin
				next_first = 1'b1;
			end
		end
	endtask

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		case (idx)
			REG_SQUEEZE_BLANK:    cfg_now.squeeze_blank    = v;
			REG_NUMBER_ALL:       cfg_now.number_all       = v;
			REG_NUMBER_NONBLANK:  cfg_now.number_nonblank  = v;
			REG_SHOW_ENDS:        cfg_now.show_ends        = v;
			REG_SHOW_TABS:        cfg_now.show_tabs        = v;
			REG_SHOW_NONPRINTING: cfg_now.show_nonprinting = v;
			default: ;
		endcase
	endtask

	task automatic set_config(cfg_t c);
		write_reg(REG_SQUEEZE_BLANK, c.squeeze_blank);
		write_reg(REG_NUMBER_ALL, c.number_all);
		write_reg(REG_NUMBER_NONBLANK, c.number_nonblank);
		write_reg(REG_SHOW_ENDS, c.show_ends);
		write_reg(REG_SHOW_TABS, c.show_tabs);
		write_reg(REG_SHOW_NONPRINTING, c.show_nonprinting);
		@(posedge clk);
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	// Holds the sender off until every expected byte has come back, then
	// leaves a settling period for a run that produced nothing.
	task automatic wait_idle();
		int guard;
		guard = 0;
		while ((raw_bytes_q.size() != 0 || in_flight || bytes_due.size() != 0)
			&& guard < DRAIN_LIMIT) begin
			@(posedge clk);
			guard++;
		end
		if (raw_bytes_q.size() != 0 || in_flight) begin
			$error("%0d input bytes were never accepted", raw_bytes_q.size() + int'(in_flight));
			fail_count++;
		end
		if (bytes_due.size() != 0) begin
			$error("%0d expected output bytes never arrived", bytes_due.size());
			fail_count++;
			bytes_due.delete();
		end
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		cfg_t c;
		in_ch.valid   = 1'b0;
		in_ch.payload = '0;
		out_ch.ready  = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		arst_n        = 1'b0;
		cfg_now       = '0;
		prev_byte     = ASCII_NL;
		blank_held    = 1'b0;
		line_bcd      = (4*DIGITS)'(1);
		idle_on       = 1'b1;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Everything visible, numbering on every line, blank lines squeezed.
		c = '0;
		c.squeeze_blank    = 1'b1;
		c.number_all       = 1'b1;
		c.show_ends        = 1'b1;
		c.show_tabs        = 1'b1;
		c.show_nonprinting = 1'b1;
		set_config(c);
		queue_raw(8'h00, 1'b1);
		queue_raw(8'h1F, 1'b0);
		queue_raw(ASCII_DEL, 1'b0);
		queue_raw(ASCII_TAB, 1'b0);
		queue_raw(8'h41, 1'b0);
		queue_raw(ASCII_NL, 1'b0);
		queue_raw(ASCII_NL, 1'b0);
		queue_raw(ASCII_NL, 1'b0);
		queue_raw(ASCII_NL, 1'b0);
		queue_raw(8'h80, 1'b0);
		queue_raw(8'hFF, 1'b0);
		queue_raw(ASCII_NL, 1'b0);
		queue_raw(8'h08, 1'b0);
		queue_raw(8'h0B, 1'b0);
		wait_idle();

		// Nonblank numbering wins over numbering every line; raw passthrough.
		c = '0;
		c.number_all      = 1'b1;
		c.number_nonblank = 1'b1;
		set_config(c);
		queue_raw(ASCII_NL, 1'b1);
		queue_raw(ASCII_NL, 1'b0);
		queue_raw(ASCII_TAB, 1'b0);
		queue_raw(ASCII_DEL, 1'b0);
		queue_raw(8'h01, 1'b0);
		queue_raw(ASCII_NL, 1'b0);
		queue_raw(ASCII_SPACE, 1'b0);
		queue_raw(8'h7E, 1'b0);
		queue_raw(ASCII_NL, 1'b0);
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			if (p == 0)
				c = '0;
			else if (p == 1)
				c = '1;
			else
				c = 6'($urandom_range(0, 63));
			// The closing phase runs with both channels flat out.
			idle_on = (p != 5);
			set_config(c);
			queue_text(36);
			wait_idle();
		end

		$display("Sent %0d text bytes under %0d register settings; checked %0d output bytes.",
			bytes_sent, settings_used, bytes_checked);
		$display("Numbered %0d lines and squeezed away %0d blank lines.",
			lines_numbered, blanks_squeezed);
		if (fail_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### files.f
+incdir+rtl/core
rtl/core/tscf_pkg.sv
rtl/core/tscf_stream_if.sv
rtl/core/text_stream_cat_filter.sv
rtl/core/tscf_checker.sv
dv/text_stream_cat_filter_test.sv
